// ===== hdl/i2cmbs_pkg.sv =====
package i2cmbs_pkg;

	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	localparam logic [2:0] TOP_BIT      = 3'd7;
	localparam logic [4:0] START_LAST   = 5'd2;
	localparam logic [4:0] STOP_LAST    = 5'd1;
	localparam logic [4:0] WRITE_LAST   = 5'd26;
	localparam logic [4:0] WRITE_BITS   = 5'd24;
	localparam logic [4:0] WRITE_ACK    = 5'd25;
	localparam logic [4:0] READ_BITS    = 5'd16;
	localparam logic [4:0] READ_DRIVE   = 5'd17;
	localparam logic [4:0] READ_ACK_HI  = 5'd18;
	localparam logic [4:0] READ_NACK_HI = 5'd19;
	localparam logic [4:0] READ_LAST_A  = 5'd19;
	localparam logic [4:0] READ_LAST_N  = 5'd20;

	typedef struct packed {
		cmd_t       cmd;
		logic [4:0] step;
		logic [7:0] shift;
		logic       ack_choice;
		logic       nack;
		logic       scl;
		logic       sda;
		logic [7:0] rd_data;
	} seq_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} seq_flags_t;

	typedef struct packed {
		logic [2:0] idx;
		logic       high;
	} wr_slot_t;

	function automatic wr_slot_t wr_slot(input logic [4:0] s);
		wr_slot_t   r;
		logic [4:0] base;
		case (s) inside
			[5'd0:5'd2]:   base = 5'd0;
			[5'd3:5'd5]:   base = 5'd3;
			[5'd6:5'd8]:   base = 5'd6;
			[5'd9:5'd11]:  base = 5'd9;
			[5'd12:5'd14]: base = 5'd12;
			[5'd15:5'd17]: base = 5'd15;
			[5'd18:5'd20]: base = 5'd18;
			default:       base = 5'd21;
		endcase
		case (base)
			5'd0:    r.idx = 3'd7;
			5'd3:    r.idx = 3'd6;
			5'd6:    r.idx = 3'd5;
			5'd9:    r.idx = 3'd4;
			5'd12:   r.idx = 3'd3;
			5'd15:   r.idx = 3'd2;
			5'd18:   r.idx = 3'd1;
			default: r.idx = 3'd0;
		endcase
		r.high = ((s - base) == 5'd1);
		return r;
	endfunction

endpackage

// ===== hdl/i2cmbs_step.sv =====
module i2cmbs_step (
	input  i2cmbs_pkg::seq_state_t cur,
	input  logic [2:0]             kind,
	input  logic [7:0]             write_byte,
	input  logic                   ack_after_read,
	input  logic                   sda_sample,
	output i2cmbs_pkg::seq_state_t nxt,
	output i2cmbs_pkg::seq_flags_t flags
);

	i2cmbs_pkg::seq_state_t st;
	i2cmbs_pkg::wr_slot_t   slot;
	logic [4:0]             last;
	logic [2:0]             bit_sel;

	assign slot    = i2cmbs_pkg::wr_slot(st.step);
	assign bit_sel = slot.idx;

	always_comb begin
		st = cur;
		if (cur.cmd == i2cmbs_pkg::CMD_IDLE
				&& kind inside {[i2cmbs_pkg::CMD_START:i2cmbs_pkg::CMD_READ]}) begin
			st.cmd  = i2cmbs_pkg::cmd_t'(kind);
			st.step = 5'd0;
			if (kind == i2cmbs_pkg::CMD_WRITE) begin
				st.shift = write_byte;
			end else if (kind == i2cmbs_pkg::CMD_READ) begin
				st.shift      = 8'd0;
				st.ack_choice = ack_after_read;
			end
		end

		nxt        = st;
		flags.busy = 1'b0;
		flags.done = 1'b0;
		last       = 5'd0;

		if (st.cmd != i2cmbs_pkg::CMD_IDLE) begin
			flags.busy = 1'b1;
			case (st.cmd)
				i2cmbs_pkg::CMD_START: begin
					nxt.sda = (st.step == 5'd0);
					nxt.scl = (st.step <= 5'd1);
					last    = i2cmbs_pkg::START_LAST;
				end
				i2cmbs_pkg::CMD_STOP: begin
					nxt.sda = (st.step != 5'd0);
					nxt.scl = 1'b1;
					last    = i2cmbs_pkg::STOP_LAST;
				end
				i2cmbs_pkg::CMD_WRITE: begin
					if (st.step < i2cmbs_pkg::WRITE_BITS) begin
						nxt.sda = st.shift[bit_sel];
						nxt.scl = slot.high;
					end else if (st.step == i2cmbs_pkg::WRITE_ACK) begin
						nxt.sda  = 1'b1;
						nxt.scl  = 1'b1;
						nxt.nack = sda_sample;
					end else begin
						nxt.sda = 1'b1;
						nxt.scl = 1'b0;
					end
					last = i2cmbs_pkg::WRITE_LAST;
				end
				i2cmbs_pkg::CMD_READ: begin
					if (st.step == 5'd0) begin
						nxt.sda = 1'b1;
						nxt.scl = 1'b0;
					end else if (st.step <= i2cmbs_pkg::READ_BITS) begin
						nxt.sda = 1'b1;
						nxt.scl = st.step[0];
						if (st.step[0]) begin
							nxt.shift = {st.shift[6:0], sda_sample};
						end
					end else if (st.step == i2cmbs_pkg::READ_DRIVE) begin
						nxt.sda = 1'b0;
						nxt.scl = 1'b0;
					end else if (!st.ack_choice) begin
						nxt.sda = 1'b1;
						nxt.scl = (st.step == i2cmbs_pkg::READ_NACK_HI);
					end else begin
						nxt.sda = 1'b0;
						nxt.scl = (st.step == i2cmbs_pkg::READ_ACK_HI);
					end
					last = st.ack_choice ? i2cmbs_pkg::READ_LAST_A
						: i2cmbs_pkg::READ_LAST_N;
					if (st.step >= last) begin
						nxt.rd_data = nxt.shift;
					end
				end
				default: begin
					last = 5'd0;
				end
			endcase
			if (st.step >= last) begin
				flags.done = 1'b1;
				nxt.cmd    = i2cmbs_pkg::CMD_IDLE;
				nxt.step   = 5'd0;
			end else begin
				nxt.step = st.step + 5'd1;
			end
		end
	end

endmodule

// ===== hdl/i2c_master_byte_sequencer.sv =====
// channel | handshake          | payload
// in      | in_valid, in_stall | kind, write_byte, ack_after_read, sda_sample
// out     | out_valid,out_stall| scl_level, sda_level, busy_res, done_res,
//         |                    | read_data, no_ack
// A result follows in the cycle after; one item per cycle while not stalled.
// The sequencer state and the result register advance together on each item.
// in_stall rises only while a result waits and out_stall is high.
// Reset leaves the sequencer idle with both lines high and no result pending.
module i2c_master_byte_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] kind,
	input  logic [7:0] write_byte,
	input  logic       ack_after_read,
	input  logic       sda_sample,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_level,
	output logic       sda_level,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_data,
	output logic       no_ack
);

	i2cmbs_pkg::seq_state_t state_q;
	i2cmbs_pkg::seq_state_t state_nxt;
	i2cmbs_pkg::seq_flags_t flags;
	logic                   out_valid_q;
	logic                   in_acc;

	assign in_stall = out_valid_q & out_stall;
	assign in_acc   = in_valid & ~in_stall;

	i2cmbs_step u_step (
		.cur            (state_q),
		.kind           (kind),
		.write_byte     (write_byte),
		.ack_after_read (ack_after_read),
		.sda_sample     (sda_sample),
		.nxt            (state_nxt),
		.flags          (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cmd        <= i2cmbs_pkg::CMD_IDLE;
			state_q.step       <= 5'd0;
			state_q.shift      <= 8'd0;
			state_q.ack_choice <= 1'b0;
			state_q.nack       <= 1'b0;
			state_q.scl        <= 1'b1;
			state_q.sda        <= 1'b1;
			state_q.rd_data    <= 8'd0;
			out_valid_q        <= 1'b0;
		end else begin
			if (in_acc) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold result payload until the next item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			scl_level <= state_nxt.scl;
			sda_level <= state_nxt.sda;
			busy_res  <= flags.busy;
			done_res  <= flags.done;
			read_data <= state_nxt.rd_data;
			no_ack    <= state_nxt.nack;
		end
	end

	assign out_valid = out_valid_q;

endmodule
